### rtl/svga_ext_pkg.sv
// Shared constants and types of the SVGA extension register port.
`default_nettype none
package svga_ext_pkg;

  localparam int PORT_W     = 10;
  localparam int DATA_W     = 8;
  localparam int STAT_W     = 4;
  localparam int VAR_W      = 3;
  localparam int KB_W       = 11;
  localparam int MASK_W     = 20;
  localparam int BANK_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam int CRTC_ENTRIES = 32;
  localparam int EXT_ENTRIES  = 32;
  localparam int CRTC_IDX_W   = $clog2(CRTC_ENTRIES);
  localparam int EXT_IDX_W    = $clog2(EXT_ENTRIES);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_VARIANT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEMORY_KB = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWITCH    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLOR     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERSCAN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIAG_SEL  = 3'd5;

  // I/O ports
  localparam logic [PORT_W-1:0] PORT_ENABLE     = 10'h3C3;
  localparam logic [PORT_W-1:0] PORT_CRTC_INDEX = 10'h3D4;
  localparam logic [PORT_W-1:0] PORT_CRTC_DATA  = 10'h3D5;
  localparam logic [PORT_W-1:0] PORT_STATUS     = 10'h3DA;
  localparam logic [PORT_W-1:0] PORT_EXT_INDEX  = 10'h3DE;
  localparam logic [PORT_W-1:0] PORT_EXT_DATA   = 10'h3DF;
  localparam logic [PORT_W-1:0] MONO_SWAP       = 10'h060;
  localparam logic [5:0]        PORT_COLOR_HI   = 6'h3D;
  localparam logic [5:0]        PORT_MONO_HI    = 6'h3B;

  // Variants
  localparam logic [VAR_W-1:0] VAR_OLDEST = 3'd0;
  localparam logic [VAR_W-1:0] VAR_MID_A  = 3'd2;
  localparam logic [VAR_W-1:0] VAR_MID_B  = 3'd3;
  localparam logic [VAR_W-1:0] VAR_MID_C  = 3'd4;
  localparam logic [VAR_W-1:0] VAR_NEW_A  = 3'd5;
  localparam logic [VAR_W-1:0] VAR_NEW_B  = 3'd6;

  // Register indexes with side effects
  localparam logic [EXT_IDX_W-1:0] EXT_MEMCTL = 5'h0D;
  localparam logic [EXT_IDX_W-1:0] EXT_SWITCH = 5'h10;
  localparam logic [EXT_IDX_W-1:0] EXT_BANK   = 5'h11;
  localparam logic [DATA_W-1:0]    EXT_RESET0 = 8'h08;

  localparam logic [CRTC_IDX_W-1:0] CRTC_OVF      = CRTC_IDX_W'(7);
  localparam logic [CRTC_IDX_W-1:0] CRTC_START_HI = CRTC_IDX_W'(12);
  localparam logic [CRTC_IDX_W-1:0] CRTC_START_LO = CRTC_IDX_W'(13);
  localparam logic [CRTC_IDX_W-1:0] CRTC_CUR_FST  = CRTC_IDX_W'(14);
  localparam logic [CRTC_IDX_W-1:0] CRTC_CUR_LST  = CRTC_IDX_W'(16);
  localparam logic [CRTC_IDX_W-1:0] CRTC_VRET_END = CRTC_IDX_W'(17);

  localparam logic [MASK_W-1:0] MASK_256K = 20'h3FFFF;
  localparam logic [MASK_W-1:0] MASK_512K = 20'h7FFFF;
  localparam logic [MASK_W-1:0] MASK_FULL = 20'hFFFFF;

  localparam logic [KB_W-1:0] KB_256  = 11'd256;
  localparam logic [KB_W-1:0] KB_512  = 11'd512;
  localparam logic [KB_W-1:0] KB_1024 = 11'd1024;

  // Overscan bit positions feeding diagnostic bits 4 and 5, by select
  localparam logic [2:0] DIAG_LO_POS [4] = '{3'd0, 3'd4, 3'd1, 3'd6};
  localparam logic [2:0] DIAG_HI_POS [4] = '{3'd2, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic capture;  // load the access into the input register
    logic exec;     // run the access against the register file
  } cmd_t;

endpackage
`default_nettype wire

### rtl/svga_ext_if.sv
// Channel interfaces: bus access request, access result and configuration write.
`default_nettype none
interface svga_ext_req_if;
  import svga_ext_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [PORT_W-1:0] port;
  logic [DATA_W-1:0] write_data;
  logic [STAT_W-1:0] display_status;
  modport source (output valid, operation, port, write_data, display_status, input ready);
  modport sink   (input valid, operation, port, write_data, display_status, output ready);
endinterface

interface svga_ext_rsp_if;
  import svga_ext_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              forward_to_core;
  logic [MASK_W-1:0] display_mask;
  logic              window_on;
  logic [BANK_W-1:0] rd_bank;
  logic [BANK_W-1:0] wr_bank;
  logic              timing_changed;
  logic              start_changed;
  modport source (output valid, read_data, forward_to_core, display_mask, window_on,
                  rd_bank, wr_bank, timing_changed, start_changed, input ready);
  modport sink   (input valid, read_data, forward_to_core, display_mask, window_on,
                  rd_bank, wr_bank, timing_changed, start_changed, output ready);
endinterface

interface svga_ext_cfg_if;
  import svga_ext_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### rtl/svga_ext_ctrl.sv
// Controller: sequences capture and execution of one access and owns the result handshake.
`default_nettype none
module svga_ext_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output svga_ext_pkg::cmd_t      cmd
);
  import svga_ext_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state, state_next;
  logic rsp_valid_next;

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid;
    cmd            = '0;
    req_ready      = 1'b0;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        // result register is free or being emptied this cycle
        req_ready = !rsp_valid || rsp_ready;
        if (req_valid && req_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec       = 1'b1;
        rsp_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

### rtl/svga_ext_dp.sv
// Datapath: configuration, index/data register files, side effects and result register.
`default_nettype none
module svga_ext_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire svga_ext_pkg::cmd_t             cmd,
  input  wire logic                           cfg_we,
  input  wire logic [svga_ext_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [svga_ext_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_operation,
  input  wire logic [svga_ext_pkg::PORT_W-1:0] in_port,
  input  wire logic [svga_ext_pkg::DATA_W-1:0] in_write_data,
  input  wire logic [svga_ext_pkg::STAT_W-1:0] in_display_status,
  output logic [svga_ext_pkg::DATA_W-1:0]     read_data,
  output logic                                forward_to_core,
  output logic [svga_ext_pkg::MASK_W-1:0]     display_mask,
  output logic                                window_on,
  output logic [svga_ext_pkg::BANK_W-1:0]     rd_bank,
  output logic [svga_ext_pkg::BANK_W-1:0]     wr_bank,
  output logic                                timing_changed,
  output logic                                start_changed
);
  import svga_ext_pkg::*;

  // configuration
  logic [VAR_W-1:0]  variant;
  logic [KB_W-1:0]   memory_kb;
  logic [DATA_W-1:0] switch_value;
  logic              color_addressing;
  logic [DATA_W-1:0] overscan_color;
  logic [1:0]        diag_select;

  // captured access
  logic              op;
  logic [PORT_W-1:0] port_q;
  logic [DATA_W-1:0] wdata;
  logic [STAT_W-1:0] stat;

  // register file state
  logic              enable_latch, enable_latch_next;
  logic [DATA_W-1:0] crtc_index, crtc_index_next;
  logic [DATA_W-1:0] ext_index, ext_index_next;
  logic [DATA_W-1:0] crtc_store [CRTC_ENTRIES];
  logic [DATA_W-1:0] ext_store [EXT_ENTRIES];
  logic [MASK_W-1:0] mask_reg, mask_reg_next;
  logic              window_reg, window_reg_next;
  logic [BANK_W-1:0] rbank_reg, rbank_reg_next;
  logic [BANK_W-1:0] wbank_reg, wbank_reg_next;

  logic                  crtc_we;
  logic [CRTC_IDX_W-1:0] crtc_addr;
  logic [DATA_W-1:0]     crtc_wval;
  logic                  ext_we;
  logic [EXT_IDX_W-1:0]  ext_addr;

  logic [DATA_W-1:0] rd_next;
  logic              fwd_next, tchg_next, schg_next;

  // combinational helpers
  logic [VAR_W-1:0]  v;
  logic              gated;
  logic [PORT_W-1:0] port_eff;
  logic              crtc_hi_blk;
  logic              crtc_prot;
  logic [DATA_W-1:0] crtc_old;
  logic [9:0]        kb_m1;
  logic [MASK_W-1:0] inst_mask;
  logic [1:0]        msel;
  logic              diag_lo, diag_hi;

  always_comb begin
    kb_m1 = memory_kb[9:0] - 10'd1;
    if (memory_kb == '0) begin
      inst_mask = '0;
    end else if (memory_kb >= KB_1024) begin
      inst_mask = MASK_FULL;
    end else begin
      inst_mask = {kb_m1, 10'h3FF};
    end
  end

  always_comb begin
    v = (variant == VAR_MID_B) ? VAR_MID_A : variant;
    gated = (v == VAR_OLDEST) && !enable_latch && (port_q != PORT_ENABLE);
    port_eff = port_q;
    if ((port_q[9:4] == PORT_COLOR_HI || port_q[9:4] == PORT_MONO_HI) &&
        port_q < PORT_EXT_INDEX && !color_addressing) begin
      port_eff = port_q ^ MONO_SWAP;
    end

    // the low index bits pick the entry under every variant
    crtc_hi_blk = (v != VAR_OLDEST) && crtc_index[5];
    crtc_addr   = crtc_index[CRTC_IDX_W-1:0];
    crtc_prot   = crtc_store[CRTC_VRET_END][7];
    crtc_old    = crtc_store[crtc_addr];
    ext_addr    = ext_index[EXT_IDX_W-1:0];
    msel        = wdata[7:6];
    diag_lo     = overscan_color[DIAG_LO_POS[diag_select]];
    diag_hi     = overscan_color[DIAG_HI_POS[diag_select]];

    enable_latch_next = enable_latch;
    crtc_index_next   = crtc_index;
    ext_index_next    = ext_index;
    mask_reg_next     = mask_reg;
    window_reg_next   = window_reg;
    rbank_reg_next    = rbank_reg;
    wbank_reg_next    = wbank_reg;
    crtc_we   = 1'b0;
    crtc_wval = wdata;
    ext_we    = 1'b0;
    rd_next   = op ? '0 : '1;
    fwd_next  = 1'b0;
    tchg_next = 1'b0;
    schg_next = 1'b0;

    if (!gated) begin
      if (op) begin
        case (port_eff)
          PORT_ENABLE: begin
            if (v == VAR_OLDEST) enable_latch_next = wdata[0];
            else fwd_next = 1'b1;
          end
          PORT_CRTC_INDEX: begin
            crtc_index_next = (v != VAR_OLDEST) ? {2'b00, wdata[5:0]} : wdata;
          end
          PORT_CRTC_DATA: begin
            if (!crtc_hi_blk && !(crtc_addr < CRTC_OVF && crtc_prot)) begin
              // with protection on, only the line compare bit of overflow is writable
              if (crtc_addr == CRTC_OVF && crtc_prot) begin
                crtc_wval = {crtc_store[CRTC_OVF][7:5], wdata[4], crtc_store[CRTC_OVF][3:0]};
              end
              crtc_we  = 1'b1;
              fwd_next = 1'b1;
              if (crtc_old != crtc_wval &&
                  (crtc_addr < CRTC_CUR_FST || crtc_addr > CRTC_CUR_LST)) begin
                if (crtc_addr == CRTC_START_HI || crtc_addr == CRTC_START_LO) schg_next = 1'b1;
                else tchg_next = 1'b1;
              end
            end
          end
          PORT_EXT_INDEX: begin
            ext_index_next = (v != VAR_OLDEST) ? {3'b000, wdata[4:0]} : wdata;
          end
          PORT_EXT_DATA: begin
            ext_we = 1'b1;
            if (ext_addr == EXT_MEMCTL) begin
              if (v == VAR_MID_C) begin
                window_reg_next = !wdata[7];
              end else if (v == VAR_MID_A) begin
                mask_reg_next   = (wdata[3:2] != 2'b00 && wdata[7]) ? inst_mask : MASK_256K;
                window_reg_next = !(wdata[7] && memory_kb == KB_256);
              end else if (v == VAR_NEW_A || v == VAR_NEW_B) begin
                mask_reg_next = MASK_256K;
                case (msel)
                  2'd0: begin
                    window_reg_next = memory_kb >= KB_256;
                    if (wdata[3:2] != 2'b00)
                      mask_reg_next = (inst_mask > MASK_256K) ? MASK_256K : inst_mask;
                  end
                  2'd2: begin
                    window_reg_next = memory_kb >= KB_512;
                    if (wdata[3:2] != 2'b00)
                      mask_reg_next = (inst_mask > MASK_512K) ? MASK_512K : inst_mask;
                  end
                  default: begin
                    window_reg_next = memory_kb >= KB_1024;
                    if (wdata[3:2] != 2'b00) mask_reg_next = inst_mask;
                  end
                endcase
              end else begin
                window_reg_next = !wdata[7];
              end
            end else if (ext_addr == EXT_BANK) begin
              rbank_reg_next = wdata[3:0];
              wbank_reg_next = wdata[7:4];
            end
          end
          default: begin
            fwd_next = 1'b1;
          end
        endcase
      end else begin
        if (port_eff == PORT_ENABLE && v == VAR_OLDEST) begin
          rd_next = {7'd0, enable_latch};
        end else if (port_eff == PORT_CRTC_INDEX) begin
          rd_next = crtc_index;
        end else if (port_eff == PORT_CRTC_DATA) begin
          rd_next = crtc_hi_blk ? '1 : crtc_old;
        end else if (port_eff == PORT_STATUS && v == VAR_OLDEST) begin
          rd_next = {2'b00, diag_hi, diag_lo, stat};
        end else if (port_eff == PORT_EXT_INDEX) begin
          rd_next = (v != VAR_OLDEST) ? {ext_index[7:5] | v, ext_index[4:0]} : ext_index;
        end else if (port_eff == PORT_EXT_DATA) begin
          rd_next = (ext_addr == EXT_SWITCH) ? switch_value : ext_store[ext_addr];
        end else begin
          fwd_next = 1'b1;
          rd_next  = '1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      variant          <= VAR_OLDEST;
      memory_kb        <= KB_512;
      switch_value     <= 8'd24;
      color_addressing <= 1'b1;
      overscan_color   <= '0;
      diag_select      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VARIANT:   variant          <= cfg_data[VAR_W-1:0];
        CFG_MEMORY_KB: memory_kb        <= cfg_data[KB_W-1:0];
        CFG_SWITCH:    switch_value     <= cfg_data[DATA_W-1:0];
        CFG_COLOR:     color_addressing <= cfg_data[0];
        CFG_OVERSCAN:  overscan_color   <= cfg_data[DATA_W-1:0];
        CFG_DIAG_SEL:  diag_select      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input capture register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= in_operation;
      port_q <= in_port;
      wdata  <= in_write_data;
      stat   <= in_display_status;
    end
  end

  // register file and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_latch <= 1'b0;
      crtc_index   <= '0;
      ext_index    <= '0;
      mask_reg     <= MASK_256K;
      window_reg   <= 1'b1;
      rbank_reg    <= '0;
      wbank_reg    <= '0;
      for (int i = 0; i < CRTC_ENTRIES; i++) crtc_store[i] <= '0;
      for (int i = 0; i < EXT_ENTRIES; i++) ext_store[i] <= (i == 0) ? EXT_RESET0 : '0;
    end else if (cmd.exec) begin
      enable_latch <= enable_latch_next;
      crtc_index   <= crtc_index_next;
      ext_index    <= ext_index_next;
      mask_reg     <= mask_reg_next;
      window_reg   <= window_reg_next;
      rbank_reg    <= rbank_reg_next;
      wbank_reg    <= wbank_reg_next;
      if (crtc_we) crtc_store[crtc_addr] <= crtc_wval;
      if (ext_we) ext_store[ext_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data       <= rd_next;
      forward_to_core <= fwd_next;
      timing_changed  <= tchg_next;
      start_changed   <= schg_next;
    end
  end

  assign display_mask = mask_reg;
  assign window_on    = window_reg;
  assign rd_bank      = rbank_reg;
  assign wr_bank      = wbank_reg;

endmodule
`default_nettype wire

### rtl/svga_extension_register_port.sv
// Top level of the SVGA extension register port.
// Each bus access is first captured into the input register and then run against the
// index/data register files, which loads the result register; no new access is taken
// while one is being run. A new access is taken while the previous result waits, as long
// as that result is taken in the same cycle or the result register is already empty.
// Configuration writes are always ready and must only be issued while no access is in
// flight. Display mask, window enable and bank fields show the state after the access
// that produced the result.
`default_nettype none
module svga_extension_register_port (
  input  wire logic       clk,
  input  wire logic       rst,
  svga_ext_req_if.sink    req,
  svga_ext_rsp_if.source  rsp,
  svga_ext_cfg_if.sink    cfg
);
  import svga_ext_pkg::*;

  cmd_t cmd;

  assign cfg.ready = 1'b1;

  svga_ext_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  svga_ext_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_we            (cfg.valid),
    .cfg_addr          (cfg.addr),
    .cfg_data          (cfg.data),
    .in_operation      (req.operation),
    .in_port           (req.port),
    .in_write_data     (req.write_data),
    .in_display_status (req.display_status),
    .read_data         (rsp.read_data),
    .forward_to_core   (rsp.forward_to_core),
    .display_mask      (rsp.display_mask),
    .window_on         (rsp.window_on),
    .rd_bank           (rsp.rd_bank),
    .wr_bank           (rsp.wr_bank),
    .timing_changed    (rsp.timing_changed),
    .start_changed     (rsp.start_changed)
  );

  // an accepted transaction leaves the result invalid while it executes, then produces its result
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !rsp.valid ##1 rsp.valid)
    else $error("result did not follow accepted transaction");

  // a new access is only taken when the result register can hold its result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> (!rsp.valid || rsp.ready))
    else $error("access accepted over a pending result");

  // a CRTC write changes either the start address or a timing register, never both
  a_change_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.timing_changed && rsp.start_changed))
    else $error("timing and start change flagged together");

endmodule
`default_nettype wire

### tb/svga_extension_register_port_test.sv
// Self-checking testbench for the SVGA extension register port.
module svga_extension_register_port_test;
  import svga_ext_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // spare variant code that the package leaves unnamed
  localparam logic [VAR_W-1:0] VAR_SPARE_HI = 3'd7;

  localparam int RESULT_LATENCY = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              forward;
    logic [MASK_W-1:0] mask;
    logic              window;
    logic [BANK_W-1:0] rbank;
    logic [BANK_W-1:0] wbank;
    logic              timing_pulse;
    logic              start_pulse;
  } access_result_t;

  logic clk;
  logic rst;

  svga_ext_req_if req ();
  svga_ext_rsp_if rsp ();
  svga_ext_cfg_if cfg ();

  svga_extension_register_port DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // register settings as last written
  logic [VAR_W-1:0]  cfg_variant;
  logic [KB_W-1:0]   cfg_kb;
  logic [DATA_W-1:0] cfg_switch;
  logic              cfg_color;
  logic [DATA_W-1:0] cfg_overscan;
  logic [1:0]        cfg_diag;

  // register file state of the port
  logic              en_latch;
  logic [DATA_W-1:0] crtc_idx;
  logic [DATA_W-1:0] crtc_regs [CRTC_ENTRIES];
  logic [DATA_W-1:0] ext_idx;
  logic [DATA_W-1:0] ext_regs [EXT_ENTRIES];
  logic [MASK_W-1:0] mask_q;
  logic              window_q;
  logic [BANK_W-1:0] rbank_q;
  logic [BANK_W-1:0] wbank_q;
  logic              last_ignored;

  access_result_t due_responses [$];

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int active_items;
  int ignored_items;
  int settings_used;
  int responses_checked;
  int fail_count;
  int stuck_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [MASK_W-1:0] memory_mask();
    int unsigned span;
    if (cfg_kb == '0)
      return '0;
    span = cfg_kb * 1024 - 1;
    return (span > 32'hFFFFF) ? MASK_FULL : MASK_W'(span);
  endfunction

  // Runs one bus access against the register state and returns the response it gives.
  function automatic access_result_t apply_access(input logic wr, input logic [PORT_W-1:0] port_in,
                                                  input logic [DATA_W-1:0] data_in,
                                                  input logic [STAT_W-1:0] stat);
    access_result_t    res;
    logic [VAR_W-1:0]  v;
    logic [PORT_W-1:0] p;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] prev;
    logic [CRTC_IDX_W-1:0] ci;
    logic [EXT_IDX_W-1:0]  ei;
    logic [MASK_W-1:0] im;
    logic [1:0]        pair;
    logic              blocked;
    v   = (cfg_variant == VAR_MID_B) ? VAR_MID_A : cfg_variant;
    p   = port_in;
    val = data_in;
    res = '0;
    res.read_data = wr ? 8'h00 : 8'hFF;
    last_ignored = (v == VAR_OLDEST) && !en_latch && (p != PORT_ENABLE);
    if (!last_ignored) begin
      if ((p[PORT_W-1:4] == PORT_COLOR_HI || p[PORT_W-1:4] == PORT_MONO_HI) &&
          p < PORT_EXT_INDEX && !cfg_color)
        p = p ^ MONO_SWAP;
      ci = crtc_idx[CRTC_IDX_W-1:0];
      ei = ext_idx[EXT_IDX_W-1:0];
      if (wr) begin
        if (p == PORT_ENABLE) begin
          if (v == VAR_OLDEST) en_latch = val[0];
          else res.forward = 1'b1;
        end else if (p == PORT_CRTC_INDEX) begin
          crtc_idx = (v != VAR_OLDEST) ? {2'b00, val[5:0]} : val;
        end else if (p == PORT_CRTC_DATA) begin
          blocked = (v != VAR_OLDEST) && crtc_idx[5];
          if (!blocked && ci < CRTC_OVF && crtc_regs[CRTC_VRET_END][7])
            blocked = 1'b1;
          if (!blocked) begin
            // overflow register: only the line compare bit stays writable
            if (ci == CRTC_OVF && crtc_regs[CRTC_VRET_END][7])
              val = (crtc_regs[CRTC_OVF] & 8'hEF) | (val & 8'h10);
            prev = crtc_regs[ci];
            crtc_regs[ci] = val;
            if (prev != val && (ci < CRTC_CUR_FST || ci > CRTC_CUR_LST)) begin
              if (ci == CRTC_START_HI || ci == CRTC_START_LO) res.start_pulse = 1'b1;
              else res.timing_pulse = 1'b1;
            end
            res.forward = 1'b1;
          end
        end else if (p == PORT_EXT_INDEX) begin
          ext_idx = (v != VAR_OLDEST) ? {3'b000, val[4:0]} : val;
        end else if (p == PORT_EXT_DATA) begin
          ext_regs[ei] = val;
          if (ei == EXT_MEMCTL) begin
            im = memory_mask();
            if (v == VAR_MID_C) begin
              window_q = !val[7];
            end else if (v == VAR_MID_A) begin
              mask_q   = (|val[3:2] && val[7]) ? im : MASK_256K;
              window_q = !(val[7] && cfg_kb == KB_256);
            end else if (v == VAR_NEW_A || v == VAR_NEW_B) begin
              mask_q = MASK_256K;
              case (val[7:6])
                2'd0: begin
                  window_q = (cfg_kb >= KB_256);
                  if (|val[3:2]) mask_q = (im < MASK_256K) ? im : MASK_256K;
                end
                2'd2: begin
                  window_q = (cfg_kb >= KB_512);
                  if (|val[3:2]) mask_q = (im < MASK_512K) ? im : MASK_512K;
                end
                default: begin
                  window_q = (cfg_kb >= KB_1024);
                  if (|val[3:2]) mask_q = im;
                end
              endcase
            end else begin
              window_q = !val[7];
            end
          end else if (ei == EXT_BANK) begin
            rbank_q = val[3:0];
            wbank_q = val[7:4];
          end
        end else begin
          res.forward = 1'b1;
        end
      end else begin
        if (p == PORT_ENABLE && v == VAR_OLDEST) begin
          res.read_data = {7'd0, en_latch};
        end else if (p == PORT_CRTC_INDEX) begin
          res.read_data = crtc_idx;
        end else if (p == PORT_CRTC_DATA) begin
          res.read_data = (v != VAR_OLDEST && crtc_idx[5]) ? 8'hFF : crtc_regs[ci];
        end else if (p == PORT_STATUS && v == VAR_OLDEST) begin
          case (cfg_diag)
            2'd0:    pair = {cfg_overscan[2], cfg_overscan[0]};
            2'd1:    pair = {cfg_overscan[5], cfg_overscan[4]};
            2'd2:    pair = {cfg_overscan[3], cfg_overscan[1]};
            default: pair = {cfg_overscan[7], cfg_overscan[6]};
          endcase
          res.read_data = {2'b00, pair, stat};
        end else if (p == PORT_EXT_INDEX) begin
          res.read_data = (v != VAR_OLDEST) ? (ext_idx | {v, 5'b00000}) : ext_idx;
        end else if (p == PORT_EXT_DATA) begin
          res.read_data = (ei == EXT_SWITCH) ? cfg_switch : ext_regs[ei];
        end else begin
          res.forward   = 1'b1;
          res.read_data = 8'hFF;
        end
      end
    end
    res.mask   = mask_q;
    res.window = window_q;
    res.rbank  = rbank_q;
    res.wbank  = wbank_q;
    return res;
  endfunction

  // CRTC-side port for the current addressing mode, now and then the other one
  function automatic logic [PORT_W-1:0] crtc_side_port(input logic [PORT_W-1:0] p);
    logic mono;
    mono = !cfg_color;
    if ($urandom_range(9) == 0)
      mono = !mono;
    return mono ? (p ^ MONO_SWAP) : p;
  endfunction

  task automatic send_access(input logic wr, input logic [PORT_W-1:0] p,
                             input logic [DATA_W-1:0] d, input logic [STAT_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.operation      <= wr;
    req.port           <= p;
    req.write_data     <= d;
    req.display_status <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    due_responses.push_back(apply_access(wr, p, d, s));
    if (last_ignored) ignored_items++;
    else active_items++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic set_config(input logic [VAR_W-1:0] var_sel, input logic [KB_W-1:0] kb,
                            input logic [DATA_W-1:0] sw, input logic col,
                            input logic [DATA_W-1:0] ovs, input logic [1:0] dsel);
    logic [CFG_ADDR_W-1:0] regs [6];
    logic [CFG_DATA_W-1:0] vals [6];
    drain();
    regs = '{CFG_VARIANT, CFG_MEMORY_KB, CFG_SWITCH, CFG_COLOR, CFG_OVERSCAN, CFG_DIAG_SEL};
    vals = '{CFG_DATA_W'(var_sel), CFG_DATA_W'(kb), CFG_DATA_W'(sw), CFG_DATA_W'(col),
             CFG_DATA_W'(ovs), CFG_DATA_W'(dsel)};
    for (int i = 0; i < 6; i++) begin
      cfg.valid <= 1'b1;
      cfg.addr  <= regs[i];
      cfg.data  <= vals[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    cfg_variant  = var_sel;
    cfg_kb       = kb;
    cfg_switch   = sw;
    cfg_color    = col;
    cfg_overscan = ovs;
    cfg_diag     = dsel;
    settings_used++;
  endtask

  // One short access sequence: mostly index write followed by data accesses.
  task automatic random_burst();
    logic [DATA_W-1:0] idx;
    int reps;
    if (cfg_variant == VAR_OLDEST && !en_latch)
      send_access(OP_WRITE, PORT_ENABLE, DATA_W'($urandom) | 8'h01, STAT_W'($urandom));
    reps = $urandom_range(1, 3);
    case ($urandom_range(9))
      0, 1, 2: begin
        idx = ($urandom_range(7) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(63));
        send_access(OP_WRITE, crtc_side_port(PORT_CRTC_INDEX), idx, STAT_W'($urandom));
        repeat (reps)
          send_access(1'($urandom_range(1)), crtc_side_port(PORT_CRTC_DATA), DATA_W'($urandom),
                      STAT_W'($urandom));
      end
      3, 4, 5: begin
        case ($urandom_range(4))
          0:       idx = DATA_W'(EXT_MEMCTL);
          1:       idx = DATA_W'(EXT_SWITCH);
          2:       idx = DATA_W'(EXT_BANK);
          3:       idx = DATA_W'($urandom_range(31));
          default: idx = DATA_W'($urandom);
        endcase
        send_access(1'($urandom_range(3) != 0), PORT_EXT_INDEX, idx, STAT_W'($urandom));
        repeat (reps)
          send_access(1'($urandom_range(1)), PORT_EXT_DATA, DATA_W'($urandom), STAT_W'($urandom));
      end
      6: send_access(1'($urandom_range(1)), PORT_ENABLE,
                     ($urandom_range(9) == 0) ? (DATA_W'($urandom) & 8'hFE)
                                              : (DATA_W'($urandom) | 8'h01),
                     STAT_W'($urandom));
      7: send_access(1'($urandom_range(1)), crtc_side_port(PORT_STATUS), DATA_W'($urandom),
                     STAT_W'($urandom));
      8: send_access(1'($urandom_range(1)), PORT_W'(10'h3B0 + $urandom_range(63)),
                     DATA_W'($urandom), STAT_W'($urandom));
      default: send_access(1'($urandom_range(1)), PORT_W'($urandom), DATA_W'($urandom),
                           STAT_W'($urandom));
    endcase
  endtask

  task automatic test_gating_and_latch();
    send_access(OP_READ,  PORT_CRTC_INDEX, 8'h00, 4'h0);
    send_access(OP_WRITE, PORT_EXT_DATA,   8'h55, 4'h0);
    send_access(OP_READ,  PORT_ENABLE,     8'h00, 4'h0);
    send_access(OP_WRITE, PORT_ENABLE,     8'h01, 4'h0);
    send_access(OP_READ,  PORT_STATUS,     8'h00, 4'hF);
    send_access(OP_READ,  PORT_W'(0),      8'h00, 4'h0);
    send_access(OP_WRITE, PORT_W'(10'h3FF), 8'hFF, 4'hF);
  endtask

  task automatic test_crtc_protection();
    send_access(OP_WRITE, PORT_CRTC_INDEX, DATA_W'(CRTC_VRET_END), 4'h0);
    send_access(OP_WRITE, PORT_CRTC_DATA,  8'h80, 4'h0);
    send_access(OP_WRITE, PORT_CRTC_INDEX, 8'h03, 4'h0);
    send_access(OP_WRITE, PORT_CRTC_DATA,  8'hFF, 4'h0);  // locked
    send_access(OP_WRITE, PORT_CRTC_INDEX, DATA_W'(CRTC_OVF), 4'h0);
    send_access(OP_WRITE, PORT_CRTC_DATA,  8'hFF, 4'h0);  // partly locked
    send_access(OP_READ,  PORT_CRTC_DATA,  8'h00, 4'h0);
    send_access(OP_WRITE, PORT_CRTC_INDEX, DATA_W'(CRTC_START_HI), 4'h0);
    send_access(OP_WRITE, PORT_CRTC_DATA,  8'hAA, 4'h0);
    // full-width indexes, used later under other variants
    send_access(OP_WRITE, PORT_CRTC_INDEX, 8'hFF, 4'h0);
    send_access(OP_WRITE, PORT_EXT_INDEX,  8'h8D, 4'h0);
  endtask

  task automatic test_variant_cases();
    set_config(VAR_MID_B, KB_1024, 8'hFF, 1'b1, 8'h00, 2'd0);
    send_access(OP_READ,  PORT_EXT_INDEX, 8'h00, 4'h0);
    send_access(OP_WRITE, PORT_CRTC_DATA, 8'h33, 4'h0);
    send_access(OP_READ,  PORT_CRTC_DATA, 8'h00, 4'h0);
    send_access(OP_WRITE, PORT_EXT_DATA,  8'h8C, 4'h0);
    send_access(OP_READ,  PORT_ENABLE,    8'h00, 4'h0);
    set_config(VAR_SPARE_HI, 11'd0, 8'h00, 1'b1, 8'hFF, 2'd0);
    send_access(OP_WRITE, PORT_EXT_DATA, 8'h80, 4'h0);
    set_config(VAR_NEW_B, 11'h7FF, 8'h5A, 1'b1, 8'h00, 2'd1);
    send_access(OP_WRITE, PORT_EXT_DATA, 8'hCC, 4'h0);
    set_config(VAR_OLDEST, KB_256, 8'h18, 1'b0, 8'hA5, 2'd3);
    send_access(OP_READ, PORT_STATUS ^ MONO_SWAP, 8'h00, 4'h9);
    send_access(OP_READ, PORT_STATUS, 8'h00, 4'h6);
  endtask

  task automatic test_random_traffic();
    logic [KB_W-1:0] kb;
    int target;
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(3))
        0:       kb = KB_256;
        1:       kb = KB_512;
        default: kb = KB_1024;
      endcase
      if (ph == 2) kb = '0;
      if (ph == 5) kb = 11'h7FF;
      set_config(VAR_W'(ph), kb,
                 (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : DATA_W'($urandom),
                 (ph % 3) != 1,
                 (ph == 8) ? 8'hFF : DATA_W'($urandom),
                 2'($urandom_range(3)));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      target = active_items + 85;
      while (active_items < target) random_burst();
    end
  endtask

  task automatic test_backpressure();
    set_config(VAR_NEW_A, KB_512, 8'h3C, 1'b1, 8'h00, 2'd0);
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (30) random_burst();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    rsp.ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_responses
    access_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_responses.size() == 0) begin
        $error("response transaction with none pending, read_data %h", rsp.read_data);
        fail_count++;
      end else begin
        want = due_responses.pop_front();
        responses_checked++;
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, rsp.read_data);
          fail_count++;
        end
        if (rsp.forward_to_core !== want.forward) begin
          $error("forward_to_core: expected %b, actual %b", want.forward, rsp.forward_to_core);
          fail_count++;
        end
        if (rsp.display_mask !== want.mask) begin
          $error("display_mask: expected %h, actual %h", want.mask, rsp.display_mask);
          fail_count++;
        end
        if (rsp.window_on !== want.window) begin
          $error("window_on: expected %b, actual %b", want.window, rsp.window_on);
          fail_count++;
        end
        if (rsp.rd_bank !== want.rbank) begin
          $error("rd_bank: expected %h, actual %h", want.rbank, rsp.rd_bank);
          fail_count++;
        end
        if (rsp.wr_bank !== want.wbank) begin
          $error("wr_bank: expected %h, actual %h", want.wbank, rsp.wr_bank);
          fail_count++;
        end
        if (rsp.timing_changed !== want.timing_pulse) begin
          $error("timing_changed: expected %b, actual %b", want.timing_pulse, rsp.timing_changed);
          fail_count++;
        end
        if (rsp.start_changed !== want.start_pulse) begin
          $error("start_changed: expected %b, actual %b", want.start_pulse, rsp.start_changed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req.valid          = 1'b0;
    req.operation      = OP_READ;
    req.port           = '0;
    req.write_data     = '0;
    req.display_status = '0;
    cfg.valid = 1'b0;
    cfg.addr  = CFG_VARIANT;
    cfg.data  = '0;
    cfg_variant  = VAR_OLDEST;
    cfg_kb       = KB_512;
    cfg_switch   = 8'd24;
    cfg_color    = 1'b1;
    cfg_overscan = '0;
    cfg_diag     = '0;
    en_latch = 1'b0;
    crtc_idx = '0;
    ext_idx  = '0;
    for (int i = 0; i < CRTC_ENTRIES; i++) crtc_regs[i] = '0;
    for (int i = 0; i < EXT_ENTRIES; i++) ext_regs[i] = '0;
    ext_regs[0]  = EXT_RESET0;
    mask_q       = MASK_256K;
    window_q     = 1'b1;
    rbank_q      = '0;
    wbank_q      = '0;
    last_ignored = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    active_items = 0;
    ignored_items = 0;
    settings_used = 0;
    responses_checked = 0;
    fail_count = 0;
    stuck_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_gating_and_latch();
    test_crtc_protection();
    test_variant_cases();
    test_random_traffic();
    test_backpressure();
    drain();

    $display("Checked %0d responses: %0d live accesses, %0d gated off, %0d register settings.",
             responses_checked, active_items, ignored_items, settings_used);
    $display("Covered all variants, memory sizes from none to saturated, idle/stall mixes, hold-off.");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
